// File: hw/rtl/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_BITS = $clog2(DEPTH + 1);

    localparam logic [ADDR_BITS:0]   DEPTH_W   = (ADDR_BITS + 1)'(DEPTH);
    localparam logic [ADDR_BITS-1:0] LAST_IDX  = ADDR_BITS'(DEPTH - 1);
    localparam logic [FILL_BITS-1:0] FULL_FILL = FILL_BITS'(DEPTH);

    typedef enum logic [2:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_POP_FRONT  = 3'd1,
        FN_PUSH_BACK  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_LIST       = 3'd4
    } deq_func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } deq_status_t;

    typedef enum logic [1:0] {
        RD_FRONT,
        RD_BACK,
        RD_LIST
    } deq_rd_t;

    typedef struct packed {
        deq_func_t   op;
        logic        do_op;
        logic        rd_en;
        deq_rd_t     rd_sel;
        logic        load_out;
        logic        word_mem;
        deq_status_t status;
        logic        last_list;
        logic        list_start;
        logic        list_step;
    } deq_cmd_t;

    typedef struct packed {
        logic out_free;
        logic empty;
        logic full;
        logic list_last;
    } deq_stat_t;

    // a, b below DEPTH, so one conditional subtract wraps the sum
    function automatic logic [ADDR_BITS-1:0] ring_add(
        input logic [ADDR_BITS-1:0] a,
        input logic [ADDR_BITS-1:0] b
    );
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

// File: hw/rtl/deq_datapath.sv
module deq_datapath
    import deq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  deq_cmd_t                    cmd,
    output deq_stat_t                   stat,
    input  logic signed [WORD_BITS-1:0] value,
    input  logic                        out_stall,
    output logic                        out_valid,
    output logic signed [WORD_BITS-1:0] word,
    output logic [1:0]                  status,
    output logic [FILL_BITS-1:0]        fill,
    output logic                        last
);

    logic signed [WORD_BITS-1:0] mem [DEPTH];

    logic [ADDR_BITS-1:0]        head_reg, head_next;
    logic [FILL_BITS-1:0]        occ_reg, occ_next;
    logic [ADDR_BITS-1:0]        k_reg, k_next;
    logic signed [WORD_BITS-1:0] rd_data_reg;
    logic                        out_valid_reg, out_valid_next;
    logic signed [WORD_BITS-1:0] word_reg;
    deq_status_t                 status_reg;
    logic [FILL_BITS-1:0]        fill_reg;
    logic                        last_reg;

    logic [FILL_BITS-1:0] occ_m1;
    logic [ADDR_BITS-1:0] head_m1;
    logic [ADDR_BITS-1:0] head_p1;
    logic [ADDR_BITS-1:0] back_idx;
    logic [ADDR_BITS-1:0] tail_idx;
    logic [ADDR_BITS-1:0] list_idx;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [ADDR_BITS-1:0] wr_addr;
    logic                 wr_en;

    assign occ_m1   = occ_reg - FILL_BITS'(1);
    assign head_m1  = (head_reg == '0) ? LAST_IDX : head_reg - ADDR_BITS'(1);
    assign head_p1  = (head_reg == LAST_IDX) ? '0 : head_reg + ADDR_BITS'(1);
    assign back_idx = ring_add(head_reg, occ_m1[ADDR_BITS-1:0]);
    assign tail_idx = ring_add(head_reg, occ_reg[ADDR_BITS-1:0]);
    assign list_idx = ring_add(head_reg, k_reg);

    assign stat.out_free  = !out_valid_reg || !out_stall;
    assign stat.empty     = (occ_reg == '0);
    assign stat.full      = (occ_reg == FULL_FILL);
    assign stat.list_last = ((FILL_BITS'(k_reg) + FILL_BITS'(1)) == occ_reg);

    always_comb
    begin
        head_next = head_reg;
        occ_next  = occ_reg;
        wr_en     = 1'b0;
        wr_addr   = tail_idx;
        if (cmd.do_op)
        begin
            unique case (cmd.op)
                FN_PUSH_FRONT:
                begin
                    head_next = head_m1;
                    occ_next  = occ_reg + FILL_BITS'(1);
                    wr_en     = 1'b1;
                    wr_addr   = head_m1;
                end
                FN_PUSH_BACK:
                begin
                    occ_next = occ_reg + FILL_BITS'(1);
                    wr_en    = 1'b1;
                    wr_addr  = tail_idx;
                end
                FN_POP_FRONT:
                begin
                    head_next = head_p1;
                    occ_next  = occ_m1;
                end
                FN_POP_BACK:
                begin
                    occ_next = occ_m1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_FRONT: rd_addr = head_reg;
            RD_BACK:  rd_addr = back_idx;
            RD_LIST:  rd_addr = list_idx;
            default:  rd_addr = head_reg;
        endcase
    end

    always_comb
    begin
        priority if (cmd.list_start)
        begin
            k_next = '0;
        end
        else if (cmd.list_step)
        begin
            k_next = k_reg + ADDR_BITS'(1);
        end
        else
        begin
            k_next = k_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            occ_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // fill reports occupancy after the operation
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            word_reg   <= cmd.word_mem ? rd_data_reg : '0;
            status_reg <= cmd.status;
            fill_reg   <= occ_next;
            last_reg   <= cmd.last_list ? stat.list_last : 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign word      = word_reg;
    assign status    = status_reg;
    assign fill      = fill_reg;
    assign last      = last_reg;

endmodule

// File: hw/rtl/deq_ctrl.sv
module deq_ctrl
    import deq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] func,
    input  deq_stat_t  stat,
    output deq_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST_RD,
        S_LIST_OUT
    } state_t;

    state_t    state_reg, state_next;
    deq_func_t fn;
    logic      accept;

    assign fn       = deq_func_t'(func);
    assign in_stall = !((state_reg == S_IDLE) && stat.out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = fn;
        cmd.do_op      = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.rd_sel     = RD_FRONT;
        cmd.load_out   = 1'b0;
        cmd.word_mem   = 1'b0;
        cmd.status     = ST_OK;
        cmd.last_list  = 1'b0;
        cmd.list_start = 1'b0;
        cmd.list_step  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (fn)
                        FN_PUSH_FRONT, FN_PUSH_BACK:
                        begin
                            cmd.load_out = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = ST_FULL;
                            end
                            else
                            begin
                                cmd.do_op = 1'b1;
                            end
                        end
                        FN_POP_FRONT, FN_POP_BACK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.status   = ST_EMPTY;
                            end
                            else
                            begin
                                // read the old end, pointers move in the same edge
                                cmd.do_op  = 1'b1;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = (fn == FN_POP_FRONT) ? RD_FRONT : RD_BACK;
                                state_next = S_POP;
                            end
                        end
                        FN_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load_out = 1'b1;
                                cmd.status   = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.list_start = 1'b1;
                                state_next     = S_LIST_RD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // output register was freed at accept
                cmd.load_out = 1'b1;
                cmd.word_mem = 1'b1;
                state_next   = S_IDLE;
            end
            S_LIST_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_LIST;
                state_next = S_LIST_OUT;
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.word_mem  = 1'b1;
                    cmd.last_list = 1'b1;
                    cmd.list_step = 1'b1;
                    state_next    = stat.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/double_ended_queue.sv
// Double-ended queue of signed words on a ring buffer of DEPTH entries.
// Input channel (in_valid/in_stall): func selects push front, pop front,
// push back, pop back or list; value is the word to push.
// Output channel (out_valid/out_stall): word, status (ok/empty/full),
// fill (words stored after the operation) and last (final result of the
// input transaction).
// Push, failed pop and list on an empty deque: result in the cycle after
// accept; the next input is taken as soon as that result is taken.
// Pop: the ring memory read is registered, then the output register is
// loaded; the input stalls meanwhile, so one pop finishes before the next.
// List: one result per stored word, front to back, each by a memory read,
// then an output load; the input stalls for the whole list.
// Unused func codes are accepted and give no result.
// A stalled result holds on the outputs, and no new input is taken until
// the output register is free or being emptied.
// Reset empties the deque at once; no clearing pass, stored words are
// only read after they were pushed.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  func,
    input  logic signed [WORD_BITS-1:0] value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WORD_BITS-1:0] word,
    output logic [1:0]                  status,
    output logic [FILL_BITS-1:0]        fill,
    output logic                        last
);

    deq_cmd_t  cmd;
    deq_stat_t stat;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .word      (word),
        .status    (status),
        .fill      (fill),
        .last      (last)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb
    import deq_pkg::*;
();

    // func codes the block accepts but ignores
    localparam logic [2:0] FN_SPARE_5 = 3'd5;
    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam int RANDOM_CHUNKS = 10;
    localparam int CHUNK_ITEMS   = 50;
    localparam int DRAIN_CYCLES  = 4000;
    localparam int TAIL_CYCLES   = 12;

    typedef struct {
        logic signed [WORD_BITS-1:0] word;
        deq_status_t                 status;
        logic [FILL_BITS-1:0]        fill;
        logic                        last;
    } deq_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [2:0]                  func;
    logic signed [WORD_BITS-1:0] value;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [WORD_BITS-1:0] word;
    logic [1:0]                  status;
    logic [FILL_BITS-1:0]        fill;
    logic                        last;

    // predictor state
    logic signed [WORD_BITS-1:0] deq_store [DEPTH];
    logic [ADDR_BITS-1:0]        deq_head;
    logic [FILL_BITS-1:0]        deq_count;

    deq_result_t pending_results [$];
    int          errors;
    int          results_seen;
    int          idle_pct;
    int          stall_left;

    double_ended_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .word      (word),
        .status    (status),
        .fill      (fill),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t result %0d: %s", $time, results_seen, msg);
        errors++;
    endtask

    // Works out the results of one accepted transaction and advances the deque.
    function automatic void apply_deque_op(input logic [2:0] op,
                                           input logic signed [WORD_BITS-1:0] data);
        deq_result_t r;
        int          slot;
        int          k;
        r.word   = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        case (op)
            FN_PUSH_FRONT, FN_PUSH_BACK:
            begin
                if (deq_count == FULL_FILL)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    if (op == FN_PUSH_FRONT)
                    begin
                        deq_head = ADDR_BITS'((int'(deq_head) + DEPTH - 1) % DEPTH);
                        slot = int'(deq_head);
                    end
                    else
                    begin
                        slot = (int'(deq_head) + int'(deq_count)) % DEPTH;
                    end
                    deq_store[slot] = data;
                    deq_count++;
                end
                r.fill = deq_count;
                pending_results.push_back(r);
            end
            FN_POP_FRONT, FN_POP_BACK:
            begin
                if (deq_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    if (op == FN_POP_FRONT)
                    begin
                        slot = int'(deq_head);
                        deq_head = ADDR_BITS'((int'(deq_head) + 1) % DEPTH);
                    end
                    else
                    begin
                        slot = (int'(deq_head) + int'(deq_count) - 1) % DEPTH;
                    end
                    r.word = deq_store[slot];
                    deq_count--;
                end
                r.fill = deq_count;
                pending_results.push_back(r);
            end
            FN_LIST:
            begin
                r.fill = deq_count;
                if (deq_count == 0)
                begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end
                else
                begin
                    for (k = 0; k < int'(deq_count); k++)
                    begin
                        r.word = deq_store[(int'(deq_head) + k) % DEPTH];
                        r.last = (k == int'(deq_count) - 1);
                        pending_results.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Called right after a rising edge; returns at the edge that accepts the transaction.
    task automatic send_item(input logic [2:0] op, input logic signed [WORD_BITS-1:0] data);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        value    <= data;
        do
            @(posedge clk);
        while (in_stall);
        apply_deque_op(op, data);
    endtask

    function automatic logic signed [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 11))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // receiver stall bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(1, 5);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // result checker: outputs are read before this edge's updates land
    initial
    begin
        deq_result_t exp_r;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result word=%0d status=%0d",
                                              word, status));
                end
                else
                begin
                    exp_r = pending_results.pop_front();
                    if (word !== exp_r.word)
                        report_mismatch($sformatf("word %0d, expected %0d",
                                                  word, exp_r.word));
                    if (status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  status, exp_r.status.name()));
                    if (fill !== exp_r.fill)
                        report_mismatch($sformatf("fill %0d, expected %0d",
                                                  fill, exp_r.fill));
                    if (last !== exp_r.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  last, exp_r.last));
                end
                results_seen++;
            end
        end
    end

    task automatic test_empty_deque();
        send_item(FN_POP_FRONT, WORD_MAX);
        send_item(FN_POP_BACK, WORD_MIN);
        send_item(FN_LIST, '1);
    endtask

    task automatic test_unused_codes();
        send_item(FN_SPARE_5, '1);
        send_item(FN_SPARE_6, WORD_MAX);
        send_item(FN_SPARE_7, WORD_MIN);
    endtask

    // fills from both ends (head wraps below zero), hits full, lists all 16
    task automatic test_fill_to_full();
        int i;
        send_item(FN_PUSH_BACK, WORD_MAX);
        send_item(FN_PUSH_FRONT, WORD_MIN);
        for (i = 2; i < DEPTH; i++)
        begin
            send_item((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, pick_word());
        end
        send_item(FN_PUSH_FRONT, 32'sd1);
        send_item(FN_PUSH_BACK, -32'sd1);
        send_item(FN_LIST, '0);
        send_item(FN_POP_FRONT, '0);
        send_item(FN_POP_BACK, '0);
    endtask

    task automatic test_random_ops();
        int chunk;
        int n;
        int r;
        int push_pct;
        logic [2:0] op;
        for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            case (chunk % 3)
                0: push_pct = 65;   // mostly filling
                1: push_pct = 22;   // mostly draining
                default: push_pct = 43;
            endcase
            if (chunk == RANDOM_CHUNKS - 1)
                idle_pct = 0;
            else
                idle_pct = 20 * $urandom_range(0, 2);
            for (n = 0; n < CHUNK_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = 3'($urandom_range(FN_SPARE_5, FN_SPARE_7));
                else if (r < 13)
                    op = FN_LIST;
                else if (r < 13 + push_pct)
                    op = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
                else
                    op = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
                send_item(op, pick_word());
            end
        end
    endtask

    task automatic wait_for_results();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_results.size()));
    endtask

    initial
    begin
        errors       = 0;
        results_seen = 0;
        idle_pct     = 25;
        stall_left   = 0;
        deq_head     = '0;
        deq_count    = '0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        func         <= FN_PUSH_BACK;
        value        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_unused_codes();
        test_fill_to_full();
        test_random_ops();
        wait_for_results();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
